// ----- hdl/ffa_pkg.sv -----
// ---------------------------------------------------------------------------
// ffa_pkg
// Types and constants shared by the first-fit free-list allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned DATA_W = 32;
  localparam logic [DATA_W-1:0] POOL_SIZE_RESET = 32'd65536;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SHDN,
    S_SHUP,
    S_OUT
  } fsm_t;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] length;
  } region_t;

  typedef struct packed {
    kind_t             kind;
    logic [DATA_W-1:0] offset;
    logic [DATA_W-1:0] size;
  } op_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] position;
  } res_t;

endpackage

// ----- hdl/ffa_cfg.sv -----
// ---------------------------------------------------------------------------
// ffa_cfg
// APB register file holding pool_size.
// ---------------------------------------------------------------------------
module ffa_cfg
  import ffa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [DATA_W-1:0] pool_size
);

  logic wr_hit;

  assign pready = 1'b1;
  // register 0 sits at byte address 0; bit 2 selects the word
  assign wr_hit = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_SIZE_RESET;
    end else if (wr_hit) begin
      pool_size <= pwdata;
    end
  end

  assign prdata = paddr[2] ? 32'd0 : pool_size;

endmodule

// ----- hdl/ffa_mem.sv -----
// ---------------------------------------------------------------------------
// ffa_mem
// Region table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ffa_mem
  import ffa_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output region_t       rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  region_t       wr_data
);

  region_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/ffa_ctrl.sv -----
// ---------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: first-fit scan, entry shifting and result register.
// ---------------------------------------------------------------------------
module ffa_ctrl
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned IW          = 4,
  parameter int unsigned CW          = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [DATA_W-1:0] pool_size,
  input  logic              in_valid,
  output logic              in_ready,
  input  op_t               in_op,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_res,
  output logic              mem_rd_en,
  output logic [IW-1:0]     mem_rd_addr,
  input  region_t           mem_rd_data,
  output logic              mem_wr_en,
  output logic [IW-1:0]     mem_wr_addr,
  output region_t           mem_wr_data
);

  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_REGIONS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  fsm_t          state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] lim, lim_next;
  logic          pend, pend_next;
  logic          go, go_next;
  op_t           op, op_next;
  region_t       prev, prev_next;
  res_t          res, res_next;
  logic          out_valid_next;
  res_t          out_res_next;
  logic          hit;
  logic [DATA_W-1:0] prev_end;

  assign prev_end = prev.start + prev.length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CNT_ONE;
      pend      <= 1'b0;
      go        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      go        <= go_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr     <= ptr_next;
    cur     <= cur_next;
    lim     <= lim_next;
    op      <= op_next;
    prev    <= prev_next;
    res     <= res_next;
    out_res <= out_res_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    ptr_next       = ptr;
    cur_next       = cur;
    lim_next       = lim;
    pend_next      = pend;
    go_next        = go;
    op_next        = op;
    prev_next      = prev;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    out_res_next   = out_res;
    in_ready       = 1'b0;
    hit            = 1'b0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = ptr[IW-1:0];
    mem_wr_en      = 1'b0;
    mem_wr_addr    = cur;
    mem_wr_data    = mem_rd_data;

    unique case (state)
      S_INIT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = '0;
        mem_wr_data = '{start: '0, length: POOL_SIZE_RESET};
        state_next  = S_IDLE;
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_next   = in_op;
          res_next  = '{status: STAT_OK, position: '0};
          ptr_next  = '0;
          pend_next = 1'b0;
          unique case (in_op.kind)
            KIND_ALLOC: state_next = S_SCAN;
            KIND_FREE:  state_next = (in_op.size == '0) ? S_OUT : S_SCAN;
            KIND_CLEAR: begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = '0;
              mem_wr_data = '{start: '0, length: pool_size};
              count_next  = CNT_ONE;
              state_next  = S_OUT;
            end
            KIND_NONE:  state_next = S_OUT;
          endcase
        end
      end

      S_SCAN: begin
        // data of entry cur arrives while entry ptr is being read
        if (pend) begin
          if (op.kind == KIND_ALLOC) begin
            if (mem_rd_data.length > op.size) begin
              hit         = 1'b1;
              mem_wr_en   = 1'b1;
              mem_wr_data = '{start:  mem_rd_data.start + op.size,
                              length: mem_rd_data.length - op.size};
              res_next    = '{status: STAT_OK, position: mem_rd_data.start};
              state_next  = S_OUT;
            end else if (mem_rd_data.length == op.size) begin
              hit      = 1'b1;
              res_next = '{status: STAT_OK, position: mem_rd_data.start};
              if (CW'(cur) + CNT_ONE == count) begin
                count_next = count - CNT_ONE;
                state_next = S_OUT;
              end else begin
                ptr_next   = CW'(cur) + CNT_ONE;
                pend_next  = 1'b0;
                state_next = S_SHDN;
              end
            end
          end else begin
            if (mem_rd_data.start > op.offset) begin
              hit = 1'b1;
              if (cur != '0 && prev_end == op.offset) begin
                // merge into the preceding region
                mem_wr_en   = 1'b1;
                mem_wr_addr = cur - IW'(1);
                mem_wr_data = '{start: prev.start, length: prev.length + op.size};
                state_next  = S_OUT;
              end else if (count == CNT_MAX) begin
                res_next   = '{status: STAT_FULL, position: '0};
                state_next = S_OUT;
              end else begin
                lim_next   = cur;
                ptr_next   = count - CNT_ONE;
                go_next    = 1'b1;
                pend_next  = 1'b0;
                state_next = S_SHUP;
              end
            end else begin
              prev_next = mem_rd_data;
            end
          end
        end
        if (!hit) begin
          if (ptr < count) begin
            mem_rd_en = 1'b1;
            cur_next  = ptr[IW-1:0];
            pend_next = 1'b1;
            ptr_next  = ptr + CNT_ONE;
          end else begin
            pend_next = 1'b0;
            if (!pend) begin
              // walked past the tail
              if (op.kind == KIND_ALLOC) begin
                res_next = '{status: STAT_NO_FIT, position: '0};
              end else if (count == CNT_MAX) begin
                res_next = '{status: STAT_FULL, position: '0};
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = count[IW-1:0];
                mem_wr_data = '{start: op.offset, length: op.size};
                count_next  = count + CNT_ONE;
              end
              state_next = S_OUT;
            end
          end
        end
      end

      S_SHDN: begin
        if (pend) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cur - IW'(1);
        end
        if (ptr < count) begin
          mem_rd_en = 1'b1;
          cur_next  = ptr[IW-1:0];
          pend_next = 1'b1;
          ptr_next  = ptr + CNT_ONE;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next = count - CNT_ONE;
            state_next = S_OUT;
          end
        end
      end

      S_SHUP: begin
        if (pend) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = cur + IW'(1);
        end
        if (go) begin
          mem_rd_en = 1'b1;
          cur_next  = ptr[IW-1:0];
          pend_next = 1'b1;
          if (ptr[IW-1:0] == lim) begin
            go_next = 1'b0;
          end else begin
            ptr_next = ptr - CNT_ONE;
          end
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            // gap is open: drop the new region in
            mem_wr_en   = 1'b1;
            mem_wr_addr = lim;
            mem_wr_data = '{start: op.offset, length: op.size};
            count_next  = count + CNT_ONE;
            state_next  = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_res_next   = res;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("region count above capacity");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> CW'(mem_wr_addr) <= count)
    else $error("write beyond the end of the region list");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("item accepted but sequencer stayed idle");

  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ptr <= count)
    else $error("scan pointer past region count");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result loaded outside result state");
`endif

endmodule

// ----- hdl/first_fit_free_list_allocator.sv -----
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator
// Address-ordered free-region list with first-fit allocate, free and clear.
// ---------------------------------------------------------------------------
// One item is processed at a time. Allocate and free read the region table
// one entry per cycle through its single read port, scanning the listed
// regions in order and then moving each later entry when a region is
// removed or inserted in the middle of the list. Clear, a zero-size free
// and an unused kind skip the scan and go straight to the result. After
// reset the block writes the initial region before it accepts its first
// item. A finished result sits in the output register, so the next item
// is taken while it waits.
module first_fit_free_list_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] offset, [63:32] size
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] position
  output logic [1:0]  m_tuser,   // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

  logic [DATA_W-1:0] pool_size;
  op_t               in_op;
  res_t              out_res;
  logic              mem_rd_en;
  logic [IW-1:0]     mem_rd_addr;
  region_t           mem_rd_data;
  logic              mem_wr_en;
  logic [IW-1:0]     mem_wr_addr;
  region_t           mem_wr_data;

  assign in_op = '{kind:   kind_t'(s_tuser),
                   offset: s_tdata[31:0],
                   size:   s_tdata[63:32]};

  assign m_tdata = out_res.position;
  assign m_tuser = out_res.status;

  ffa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pool_size (pool_size)
  );

  ffa_mem #(
    .DEPTH (MAX_REGIONS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  ffa_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pool_size   (pool_size),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (in_op),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (out_res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

endmodule

// ----- tb/first_fit_free_list_allocator_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator_test
// Self-checking bench for the first-fit free-list allocator. A local copy of
// the free list predicts the status and position of every allocate, free,
// clear and unused request. Directed cases come first, then random traffic
// over several pool sizes with random stalls on both streams in all but the last run.
// ---------------------------------------------------------------------------
module first_fit_free_list_allocator_test;
  import ffa_pkg::*;

  localparam int REGION_SLOTS = 16;
  localparam logic [2:0] REG_POOL_SIZE = 3'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] offset, [63:32] size
  logic [1:0]  s_tuser = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] position
  logic [1:0]  m_tuser;        // [1:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  first_fit_free_list_allocator #(
    .MAX_REGIONS(REGION_SLOTS)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the free list
  logic [31:0] pool_len_cfg = POOL_SIZE_RESET;
  region_t     free_list[REGION_SLOTS];
  int          region_total;

  region_t     live_blocks[$];   // allocations not yet handed back
  res_t        awaited_replies[$];
  int          mismatches;
  int          kind_count[4];
  int          status_count[4];
  int          send_gap_pct;
  int          recv_gap_pct;

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
  endfunction

  function automatic void rebuild_free_list();
    free_list[0].start = '0;
    free_list[0].length = pool_len_cfg;
    region_total = 1;
  endfunction

  function automatic void add_region(int idx, logic [31:0] start, logic [31:0] length);
    for (int k = region_total; k > idx; k--)
      free_list[k] = free_list[k - 1];
    free_list[idx].start = start;
    free_list[idx].length = length;
    region_total++;
  endfunction

  function automatic void drop_region(int idx);
    for (int k = idx; k + 1 < region_total; k++)
      free_list[k] = free_list[k + 1];
    region_total--;
  endfunction

  // Applies one request to the local list and returns the reply it earns
  function automatic res_t apply_request(kind_t kind, logic [31:0] offset, logic [31:0] size);
    res_t        r;
    int          at;
    logic [31:0] prev_end;
    r.status = STAT_OK;
    r.position = '0;
    at = -1;
    prev_end = '0;
    case (kind)
      KIND_ALLOC: begin
        // first region at least as long as the request
        for (int k = 0; k < region_total && at < 0; k++)
          if (free_list[k].length >= size) at = k;
        if (at < 0) begin
          r.status = STAT_NO_FIT;
        end else begin
          r.position = free_list[at].start;
          if (free_list[at].length == size) begin
            drop_region(at);
          end else begin
            free_list[at].start += size;
            free_list[at].length -= size;
          end
        end
      end
      KIND_FREE: begin
        if (size != 0) begin
          for (int k = 0; k < region_total && at < 0; k++)
            if (free_list[k].start > offset) at = k;
          if (at > 0) prev_end = free_list[at - 1].start + free_list[at - 1].length;
          // merge only backwards, and never on the tail append
          if (at > 0 && prev_end == offset) free_list[at - 1].length += size;
          else if (region_total >= REGION_SLOTS) r.status = STAT_FULL;
          else if (at >= 0) add_region(at, offset, size);
          else add_region(region_total, offset, size);
        end
      end
      KIND_CLEAR: rebuild_free_list();
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(kind_t kind, logic [31:0] offset, logic [31:0] size);
    res_t    r;
    region_t blk;
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {size, offset};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = apply_request(kind, offset, size);
    awaited_replies = {awaited_replies, r};
    kind_count[int'(kind)]++;
    status_count[int'(r.status)]++;
    if (kind == KIND_ALLOC && r.status == STAT_OK && size != 0) begin
      blk.start = r.position;
      blk.length = size;
      live_blocks = {live_blocks, blk};
    end
    if (kind == KIND_CLEAR) live_blocks.delete();
  endtask

  // Hold the sender off until every outstanding reply is back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_replies.size() != 0);
  endtask

  task automatic write_pool_size(logic [31:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_POOL_SIZE;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pool_len_cfg = value;
    // straight into a read of the same register
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) flag_mismatch("pool_size readback", value, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_alloc_and_free();
    send_request(KIND_ALLOC, '0, 32'd0);
    send_request(KIND_ALLOC, '0, 32'd100);
    send_request(KIND_ALLOC, '0, 32'd65436);          // exact fit empties the list
    send_request(KIND_ALLOC, '0, 32'd1);              // empty list
    send_request(KIND_FREE, 32'd5, 32'd0);            // zero-size free
    send_request(KIND_FREE, 32'd100, 32'd50);
    send_request(KIND_FREE, 32'd0, 32'd100);          // insert at head
    send_request(KIND_FREE, 32'd150, 32'd10);         // tail append, no merge
    send_request(KIND_FREE, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_request(KIND_ALLOC, '0, 32'hFFFF_FFFF);
    send_request(KIND_FREE, 32'd200, 32'd5);
    send_request(KIND_FREE, 32'd160, 32'd3);          // merges into preceding region
    send_request(KIND_ALLOC, '0, 32'd13);
    send_request(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_CLEAR, '0, '0);
  endtask

  task automatic test_pool_size_extremes();
    write_pool_size('0);
    send_request(KIND_CLEAR, '0, '0);
    send_request(KIND_ALLOC, '0, 32'd5);
    send_request(KIND_ALLOC, '0, 32'd0);              // takes the zero-length region
    send_request(KIND_ALLOC, '0, 32'd0);
    send_request(KIND_FREE, 32'd7, 32'd3);
    write_pool_size(32'hFFFF_FFFF);
    send_request(KIND_CLEAR, '0, '0);
    send_request(KIND_ALLOC, '0, 32'hFFFF_FFFF);
    send_request(KIND_ALLOC, '0, 32'd1);
    write_pool_size(32'd1);
    send_request(KIND_CLEAR, '0, '0);
    send_request(KIND_ALLOC, '0, 32'd1);
  endtask

  task automatic random_request();
    int          pick;
    int          idx;
    logic [31:0] span;
    logic [31:0] amount;
    region_t     blk;
    span = (pool_len_cfg > 32'h0010_0000) ? 32'h0010_0000 : pool_len_cfg;
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_request(KIND_CLEAR, $urandom, $urandom);
    end else if (pick < 5) begin
      send_request(KIND_NONE, $urandom, $urandom);
    end else if (pick < 40) begin
      if (pick < 9) amount = '0;
      else if (pick < 14 && region_total > 0)
        amount = free_list[$urandom_range(region_total - 1)].length;
      else if (pick < 16) amount = $urandom;
      else amount = $urandom_range(span / 6 + 1, 1);
      send_request(KIND_ALLOC, $urandom, amount);
    end else if (pick < 75 && live_blocks.size() > 0) begin
      idx = $urandom_range(live_blocks.size() - 1);
      blk = live_blocks[idx];
      live_blocks.delete(idx);
      send_request(KIND_FREE, blk.start, blk.length);
    end else if (pick < 92) begin
      // scattered small frees fragment the list until it fills
      send_request(KIND_FREE, $urandom_range(span + span / 2), $urandom_range(8, 1));
    end else begin
      send_request(KIND_FREE, $urandom, $urandom);
    end
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, logic [31:0] pool, int count);
    write_pool_size(pool);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    send_request(KIND_CLEAR, '0, '0);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain();
      random_request();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_replies.size() == 0) begin
        flag_mismatch("reply with nothing outstanding", '0, m_tdata);
      end else begin
        want = awaited_replies.pop_front();
        if (m_tuser !== want.status) flag_mismatch("status", want.status, m_tuser);
        if (m_tdata !== want.position) flag_mismatch("position", want.position, m_tdata);
      end
    end
  end

  initial begin
    mismatches = 0;
    send_gap_pct = 38;
    recv_gap_pct = 75;
    rebuild_free_list();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_alloc_and_free();
    test_pool_size_extremes();
    test_random_traffic(38, 75, 32'd4096, 300);
    test_random_traffic(75, 38, 32'd200, 300);
    test_random_traffic(0, 0, $urandom_range(32'h0010_0000, 32'd64), 330);

    drain();
    repeat (48) @(posedge clk);
    $display("Covered %0d allocate, %0d free, %0d clear and %0d unused-kind requests,",
             kind_count[KIND_ALLOC], kind_count[KIND_FREE], kind_count[KIND_CLEAR],
             kind_count[KIND_NONE]);
    $display("pool sizes 0 to all-ones; %0d done, %0d no fit, %0d frees dropped on a full list",
             status_count[STAT_OK], status_count[STAT_NO_FIT], status_count[STAT_FULL]);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("first_fit_free_list_allocator_test OK");
    end else begin
      $display("first_fit_free_list_allocator_test NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d replies outstanding", awaited_replies.size());
    $display("first_fit_free_list_allocator_test NOT OK");
    $finish;
  end

endmodule
